// ----- hw/rtl/apl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list package
// Shared widths, command and status codes, and the record layout.
// ----------------------------------------------------------------------------
package apl_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned POS_W    = 7;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned NAME_W   = 64;
  localparam int unsigned NAME_C_W = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FOUND_W  = 6;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [NAME_W-1:0]   name_a;
    logic [NAME_W-1:0]   name_b;
    logic [NAME_C_W-1:0] name_c;
  } record_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } store_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/positional_array_list_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list
// Ordered fixed-capacity list of key and name records with insert, delete,
// search by key and clear.
//
//   Channel  Handshake             Payload
//   in       in_valid_i/in_stall_o   cmd, position, key, name parts a, b, c
//   out      out_valid_o/out_stall_i status, found_index, entry_count, flags
//
// After an item is taken the input stalls until the sequencer is idle again:
// an insert or delete shifts the later entries one place over, and a search
// walks the list from the front until a hit, both through the single store
// read port, walked one entry per cycle. Reset empties the list at once.
// The next item is taken while a result waits on a stalled output, and the
// one after waits for that result to go.
// ----------------------------------------------------------------------------
module positional_array_list_top
  import apl_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire [1:0]              cmd_i,
  input  wire [POS_W-1:0]        position_i,
  input  wire signed [KEY_W-1:0] key_i,
  input  wire [NAME_W-1:0]       name_part_a_i,
  input  wire [NAME_W-1:0]       name_part_b_i,
  input  wire [NAME_C_W-1:0]     name_part_c_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [FOUND_W-1:0]     found_index_o,
  output logic [COUNT_W-1:0]     entry_count_o,
  output logic                   is_empty_o,
  output logic                   is_full_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  store_ctl_t       st_ctl;
  logic [IDX_W-1:0] st_waddr;
  logic [IDX_W-1:0] st_raddr;
  record_t          st_wdata;
  record_t          st_rdata;

  apl_seq #(
    .CAPACITY(CAPACITY),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .key_i        (key_i),
    .name_part_a_i(name_part_a_i),
    .name_part_b_i(name_part_b_i),
    .name_part_c_i(name_part_c_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .found_index_o(found_index_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o),
    .st_ctl_o     (st_ctl),
    .st_waddr_o   (st_waddr),
    .st_wdata_o   (st_wdata),
    .st_raddr_o   (st_raddr),
    .st_rdata_i   (st_rdata)
  );

  apl_store #(
    .DEPTH (CAPACITY),
    .ADDR_W(IDX_W)
  ) u_store (
    .clk_i  (clk_i),
    .ctl_i  (st_ctl),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/apl_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Record store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module apl_store
  import apl_pkg::*;
#(
  parameter int unsigned DEPTH  = CAPACITY_DEF,
  parameter int unsigned ADDR_W = 6
) (
  input  wire              clk_i,
  input  store_ctl_t       ctl_i,
  input  wire [ADDR_W-1:0] waddr_i,
  input  record_t          wdata_i,
  input  wire [ADDR_W-1:0] raddr_i,
  output record_t          rdata_o
);

  record_t mem_q [DEPTH];
  record_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hw/rtl/apl_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Command sequencer
// Checks each command, walks the store one entry per cycle to shift or
// search, and holds the result in an output register.
// ----------------------------------------------------------------------------
module apl_seq
  import apl_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CNT_W    = 7
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire [1:0]              cmd_i,
  input  wire [POS_W-1:0]        position_i,
  input  wire signed [KEY_W-1:0] key_i,
  input  wire [NAME_W-1:0]       name_part_a_i,
  input  wire [NAME_W-1:0]       name_part_b_i,
  input  wire [NAME_C_W-1:0]     name_part_c_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [FOUND_W-1:0]     found_index_o,
  output logic [COUNT_W-1:0]     entry_count_o,
  output logic                   is_empty_o,
  output logic                   is_full_o,
  output store_ctl_t             st_ctl_o,
  output logic [IDX_W-1:0]       st_waddr_o,
  output record_t                st_wdata_o,
  output logic [IDX_W-1:0]       st_raddr_o,
  input  record_t                st_rdata_i
);

  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_LAST = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  cmd_e                 cmd_q, cmd_d;
  logic [CNT_W-1:0]     pos_q, pos_d;
  record_t              rec_q, rec_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [IDX_W-1:0]     ptr_q, ptr_d;
  logic                 pend_q, pend_d;
  logic [IDX_W-1:0]     pend_idx_q, pend_idx_d;
  status_e              status_q, status_d;
  logic [IDX_W-1:0]     found_q, found_d;
  logic                 out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;
  logic [FOUND_W-1:0]   out_found_q, out_found_d;
  logic [COUNT_W-1:0]   out_count_q, out_count_d;
  logic                 out_empty_q, out_empty_d;
  logic                 out_full_q, out_full_d;

  cmd_e                 cmd_in;
  logic [CMP_W-1:0]     pos_ext;
  logic [CMP_W-1:0]     cnt_ext;
  logic [CNT_W-1:0]     pos_in;
  logic [CNT_W-1:0]     cnt_last;
  logic                 list_full;
  logic                 list_empty;
  logic                 hit;
  logic                 last_rd;
  logic [IDX_W-1:0]     mv_addr;

  assign cmd_in     = cmd_e'(cmd_i);
  assign pos_ext    = CMP_W'(position_i);
  assign cnt_ext    = CMP_W'(cnt_q);
  assign pos_in     = CNT_W'(position_i);
  assign cnt_last   = cnt_q - CNT_W'(1);
  assign list_full  = (cnt_q == CNT_W'(CAPACITY));
  assign list_empty = (cnt_q == '0);
  assign hit        = pend_q && (st_rdata_i.key == rec_q.key);
  assign last_rd    = (cmd_q == CMD_INSERT) ? (CNT_W'(ptr_q) == pos_q)
                                            : (CNT_W'(ptr_q) == cnt_last);
  assign mv_addr    = (cmd_q == CMD_INSERT) ? (pend_idx_q + IDX_W'(1))
                                            : (pend_idx_q - IDX_W'(1));

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    pos_d        = pos_q;
    rec_d        = rec_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    status_d     = status_q;
    found_d      = found_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_count_d  = out_count_q;
    out_empty_d  = out_empty_q;
    out_full_d   = out_full_q;
    st_ctl_o     = '0;
    st_waddr_o   = mv_addr;
    st_wdata_o   = st_rdata_i;
    st_raddr_o   = ptr_q;

    // A shifted entry read in the previous cycle is written one place over.
    if (pend_q && (cmd_q != CMD_SEARCH) && (state_q != S_IDLE)) begin
      st_ctl_o.wr_en = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = cmd_in;
          pos_d    = pos_in;
          rec_d    = '{key: key_i, name_a: name_part_a_i,
                       name_b: name_part_b_i, name_c: name_part_c_i};
          status_d = ST_OK;
          found_d  = '0;
          pend_d   = 1'b0;
          state_d  = S_FIN;
          unique case (cmd_in)
            CMD_INSERT: begin
              if (list_full) begin
                status_d = ST_FULL;
              end else if (pos_ext > cnt_ext) begin
                status_d = ST_BAD_INDEX;
              end else if (pos_ext == cnt_ext) begin
                state_d = S_LAST;
              end else begin
                ptr_d   = IDX_W'(cnt_last);
                state_d = S_RUN;
              end
            end
            CMD_DELETE: begin
              if (list_empty) begin
                status_d = ST_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                status_d = ST_BAD_INDEX;
              end else if (pos_ext == cnt_ext - CMP_W'(1)) begin
                state_d = S_LAST;
              end else begin
                ptr_d   = IDX_W'(pos_in + CNT_W'(1));
                state_d = S_RUN;
              end
            end
            CMD_SEARCH: begin
              if (list_empty) begin
                status_d = ST_NOT_FOUND;
              end else begin
                ptr_d   = '0;
                state_d = S_RUN;
              end
            end
            CMD_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_RUN: begin
        if ((cmd_q == CMD_SEARCH) && hit) begin
          status_d = ST_OK;
          found_d  = pend_idx_q;
          pend_d   = 1'b0;
          state_d  = S_FIN;
        end else begin
          st_ctl_o.rd_en = 1'b1;
          pend_d         = 1'b1;
          pend_idx_d     = ptr_q;
          ptr_d          = (cmd_q == CMD_INSERT) ? (ptr_q - IDX_W'(1))
                                                 : (ptr_q + IDX_W'(1));
          if (last_rd) begin
            state_d = S_LAST;
          end
        end
      end
      S_LAST: begin
        pend_d = 1'b0;
        if (pend_q) begin
          if (cmd_q == CMD_SEARCH) begin
            status_d = hit ? ST_OK : ST_NOT_FOUND;
            found_d  = hit ? pend_idx_q : '0;
            state_d  = S_FIN;
          end
        end else if (cmd_q == CMD_INSERT) begin
          st_ctl_o.wr_en = 1'b1;
          st_waddr_o     = IDX_W'(pos_q);
          st_wdata_o     = rec_q;
          cnt_d          = cnt_q + CNT_W'(1);
          state_d        = S_FIN;
        end else begin
          cnt_d   = cnt_last;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_found_d  = FOUND_W'(found_q);
          out_count_d  = COUNT_W'(cnt_q);
          out_empty_d  = list_empty;
          out_full_d   = list_full;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    pos_q        <= pos_d;
    rec_q        <= rec_d;
    ptr_q        <= ptr_d;
    pend_idx_q   <= pend_idx_d;
    status_q     <= status_d;
    found_q      <= found_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_count_q  <= out_count_d;
    out_empty_q  <= out_empty_d;
    out_full_q   <= out_full_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_index_o = out_found_q;
  assign entry_count_o = out_count_q;
  assign is_empty_o    = out_empty_q;
  assign is_full_o     = out_full_q;

endmodule
`default_nettype wire

// ----- hw/rtl/apl_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list checker
// Port-level checks on result consistency and output hold under stall.
// ----------------------------------------------------------------------------
module apl_checker
  import apl_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_stall_o,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input wire [STATUS_W-1:0]  status_o,
  input wire [FOUND_W-1:0]   found_index_o,
  input wire [COUNT_W-1:0]   entry_count_o,
  input wire                 is_empty_o,
  input wire                 is_full_o
);

  localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(found_index_o) && $stable(entry_count_o))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with entry count");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_full_o == (entry_count_o == CAP_COUNT)))
    else $error("full flag disagrees with entry count");

  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (found_index_o == '0))
    else $error("found index set on a refused or missed command");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted without the block going busy");

endmodule

bind positional_array_list_top apl_checker #(.CAPACITY(CAPACITY)) u_apl_checker (.*);
`default_nettype wire

// ----- dv/positional_array_list_checker.sv -----
// ----------------------------------------------------------------------------
// Positional array list checker
// Watches both channels of the list block. Every command item accepted on the
// input updates a private copy of the list and queues the result it should
// produce; every result item accepted on the output is compared field by field
// with the oldest queued result. The mismatch count and the number of results
// still owed are handed to the testbench top.
// ----------------------------------------------------------------------------
module positional_array_list_checker
  import apl_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  input  wire                  in_stall_i,
  input  wire [1:0]            cmd_i,
  input  wire [POS_W-1:0]      position_i,
  input  wire [KEY_W-1:0]      key_i,
  input  wire [NAME_W-1:0]     name_part_a_i,
  input  wire [NAME_W-1:0]     name_part_b_i,
  input  wire [NAME_C_W-1:0]   name_part_c_i,
  input  wire                  out_valid_i,
  input  wire                  out_stall_i,
  input  wire [STATUS_W-1:0]   status_i,
  input  wire [FOUND_W-1:0]    found_index_i,
  input  wire [COUNT_W-1:0]    entry_count_i,
  input  wire                  is_empty_i,
  input  wire                  is_full_i,
  output int                   fail_count_o,
  output int                   outstanding_o
);

  localparam int unsigned LIST_CAP    = CAPACITY_DEF;
  localparam int          MAX_PRINTED = 100;

  typedef struct packed {
    status_e            status;
    logic [FOUND_W-1:0] found;
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic               full;
  } list_answer_t;

  record_t      list_rec [LIST_CAP];
  int unsigned  list_len;
  list_answer_t answers_q [$];
  list_answer_t oldest_answer;
  int           mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic list_answer_t apply_list_command(input cmd_e op, input int unsigned pos,
                                                      input record_t rec);
    list_answer_t ans;
    ans = '0;
    ans.status = ST_OK;
    case (op)
      CMD_INSERT: begin
        if (list_len >= LIST_CAP) begin
          ans.status = ST_FULL;
        end else if (pos > list_len) begin
          ans.status = ST_BAD_INDEX;
        end else begin
          for (int unsigned i = list_len; i > pos; i--) list_rec[i] = list_rec[i-1];
          list_rec[pos] = rec;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (list_len == 0) begin
          ans.status = ST_EMPTY;
        end else if (pos >= list_len) begin
          ans.status = ST_BAD_INDEX;
        end else begin
          for (int unsigned i = pos; i + 1 < list_len; i++) list_rec[i] = list_rec[i+1];
          list_len--;
        end
      end
      CMD_SEARCH: begin
        ans.status = ST_NOT_FOUND;
        for (int unsigned i = 0; i < list_len; i++) begin
          if (list_rec[i].key == rec.key) begin
            ans.status = ST_OK;
            ans.found  = FOUND_W'(i);
            break;
          end
        end
      end
      default: begin
        list_len = 0;
      end
    endcase
    ans.count = COUNT_W'(list_len);
    ans.empty = (list_len == 0);
    ans.full  = (list_len == LIST_CAP);
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      answers_q.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (answers_q.size() == 0) begin
          report_mismatch($sformatf("result item with no command waiting, status %0d",
                                    status_i));
        end else begin
          oldest_answer = answers_q.pop_front();
          if (status_i !== oldest_answer.status) begin
            report_mismatch($sformatf("status %0d, wanted %0d", status_i,
                                      oldest_answer.status));
          end
          if (found_index_i !== oldest_answer.found) begin
            report_mismatch($sformatf("found_index %0d, wanted %0d", found_index_i,
                                      oldest_answer.found));
          end
          if (entry_count_i !== oldest_answer.count) begin
            report_mismatch($sformatf("entry_count %0d, wanted %0d", entry_count_i,
                                      oldest_answer.count));
          end
          if (is_empty_i !== oldest_answer.empty) begin
            report_mismatch($sformatf("is_empty %b, wanted %b", is_empty_i,
                                      oldest_answer.empty));
          end
          if (is_full_i !== oldest_answer.full) begin
            report_mismatch($sformatf("is_full %b, wanted %b", is_full_i,
                                      oldest_answer.full));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        answers_q.push_back(apply_list_command(cmd_e'(cmd_i), position_i,
                                               record_t'{key_i, name_part_a_i,
                                                         name_part_b_i, name_part_c_i}));
      end
      outstanding_o <= answers_q.size();
    end
  end

endmodule

// ----- dv/tb_positional_array_list_top.sv -----
// ----------------------------------------------------------------------------
// Positional array list testbench
// Drives command items into the list block: a directed opening that covers
// empty, bad-index, duplicate-key and clear cases, then phases of random
// commands biased to grow, shrink or mix the list so that the full case is
// reached often. Both channels idle at random, with one quiet stretch, one
// long output hold-off and one pause until the block has answered every item.
// The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_positional_array_list_top;
  import apl_pkg::*;

  localparam int unsigned LIST_CAP     = CAPACITY_DEF;
  localparam int unsigned ITEM_TOTAL   = 950;
  localparam int unsigned PHASE_ITEMS  = 80;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned QUIET_FIRST  = 300;
  localparam int unsigned QUIET_LAST   = 450;
  localparam int unsigned HOLD_AT      = 600;
  localparam int unsigned PAUSE_AT     = 750;
  localparam int unsigned IDLE_PCT     = 12;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} phase_e;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              cmd_i;
  logic [POS_W-1:0]        position_i;
  logic signed [KEY_W-1:0] key_i;
  logic [NAME_W-1:0]       name_part_a_i;
  logic [NAME_W-1:0]       name_part_b_i;
  logic [NAME_C_W-1:0]     name_part_c_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [STATUS_W-1:0]     status_o;
  logic [FOUND_W-1:0]      found_index_o;
  logic [COUNT_W-1:0]      entry_count_o;
  logic                    is_empty_o;
  logic                    is_full_o;

  int          fail_count;
  int          outstanding;
  int unsigned accepted = 0;
  int unsigned shadow_len = 0;
  int unsigned cycles = 0;
  bit          hold_done = 0;

  positional_array_list_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .key_i        (key_i),
    .name_part_a_i(name_part_a_i),
    .name_part_b_i(name_part_b_i),
    .name_part_c_i(name_part_c_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .found_index_o(found_index_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o),
    .is_full_o    (is_full_o)
  );

  positional_array_list_checker list_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .key_i        (key_i),
    .name_part_a_i(name_part_a_i),
    .name_part_b_i(name_part_b_i),
    .name_part_c_i(name_part_c_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (status_o),
    .found_index_i(found_index_o),
    .entry_count_i(entry_count_o),
    .is_empty_i   (is_empty_o),
    .is_full_i    (is_full_o),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit quiet_stretch();
    return accepted >= QUIET_FIRST && accepted < QUIET_LAST;
  endfunction

  // Most keys come from a small pool so that searches hit and duplicates occur.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return KEY_W'($urandom_range(0, 7)) - KEY_W'(4);
    end else if (roll < 65) begin
      return $urandom_range(0, 1) ? {1'b1, {(KEY_W-1){1'b0}}} : {1'b0, {(KEY_W-1){1'b1}}};
    end
    return $urandom;
  endfunction

  task automatic offer_command(input cmd_e op, input logic [POS_W-1:0] pos,
                               input logic [KEY_W-1:0] key, input logic [NAME_W-1:0] na,
                               input logic [NAME_W-1:0] nb, input logic [NAME_C_W-1:0] nc);
    if (!quiet_stretch() && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    cmd_i         <= op;
    position_i    <= pos;
    key_i         <= key;
    name_part_a_i <= na;
    name_part_b_i <= nb;
    name_part_c_i <= nc;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    accepted++;
    case (op)
      CMD_INSERT: if (shadow_len < LIST_CAP && pos <= shadow_len) shadow_len++;
      CMD_DELETE: if (shadow_len != 0 && pos < shadow_len) shadow_len--;
      CMD_CLEAR:  shadow_len = 0;
      default:    ;
    endcase
  endtask

  // Output side: random stall, one quiet stretch, one long hold-off.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && accepted >= HOLD_AT) begin
        out_stall_i <= 1'b1;
        hold_done = 1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= !quiet_stretch() && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL positional_array_list_top");
    $finish;
  end

  initial begin
    phase_e           phase;
    cmd_e             op;
    int unsigned      roll;
    int unsigned      block;
    bit               paused;
    logic [POS_W-1:0] pos;
    logic [KEY_W-1:0] key;

    paused        = 0;
    block         = 0;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    cmd_i         <= CMD_SEARCH;
    position_i    <= '0;
    key_i         <= '0;
    name_part_a_i <= '0;
    name_part_b_i <= '0;
    name_part_c_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list, bad indexes, duplicate keys, extremes of every field.
    offer_command(CMD_DELETE, 7'd0, 32'd0, '0, '0, '0);
    offer_command(CMD_SEARCH, 7'd0, 32'd0, '0, '0, '0);
    offer_command(CMD_INSERT, 7'd1, 32'd5, '1, '1, '1);
    offer_command(CMD_INSERT, 7'd0, 32'h8000_0000, '1, '1, '1);
    offer_command(CMD_INSERT, 7'd1, 32'h7FFF_FFFF, '0, '0, '0);
    offer_command(CMD_INSERT, 7'd0, 32'hFFFF_FFFF, {$urandom, $urandom},
                  {$urandom, $urandom}, $urandom);
    offer_command(CMD_INSERT, 7'd3, 32'h8000_0000, {$urandom, $urandom},
                  {$urandom, $urandom}, $urandom);
    offer_command(CMD_SEARCH, 7'd0, 32'h8000_0000, '0, '0, '0);
    offer_command(CMD_SEARCH, 7'd0, 32'h7FFF_FFFF, '0, '0, '0);
    offer_command(CMD_SEARCH, 7'd0, 32'd0, '0, '0, '0);
    offer_command(CMD_DELETE, 7'd4, 32'd0, '0, '0, '0);
    offer_command(CMD_DELETE, 7'd127, 32'd0, '0, '0, '0);
    offer_command(CMD_INSERT, 7'd127, 32'd9, '1, '0, '1);
    offer_command(CMD_INSERT, 7'd5, 32'd9, '0, '1, '0);
    offer_command(CMD_DELETE, 7'd0, 32'd0, '0, '0, '0);
    offer_command(CMD_DELETE, 7'd2, 32'd0, '0, '0, '0);
    offer_command(CMD_SEARCH, 7'd0, 32'h8000_0000, '0, '0, '0);
    offer_command(CMD_CLEAR, 7'd0, 32'd0, '0, '0, '0);
    offer_command(CMD_CLEAR, 7'd0, 32'd0, '0, '0, '0);
    offer_command(CMD_SEARCH, 7'd0, 32'h7FFF_FFFF, '0, '0, '0);
    offer_command(CMD_DELETE, 7'd0, 32'd0, '0, '0, '0);

    // The first two phases are biased to grow the list towards full.
    while (accepted < ITEM_TOTAL) begin
      if (block < 2) begin
        phase = PH_GROW;
      end else if (block == 2) begin
        phase = PH_SHRINK;
      end else begin
        phase = phase_e'($urandom_range(0, 2));
      end
      block++;
      repeat (PHASE_ITEMS) begin
        if (!paused && accepted >= PAUSE_AT) begin
          paused = 1;
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (outstanding != 0);
        end
        roll = $urandom_range(0, 99);
        case (phase)
          PH_GROW:   op = roll < 80 ? CMD_INSERT : roll < 85 ? CMD_DELETE :
                          roll < 99 ? CMD_SEARCH : CMD_CLEAR;
          PH_SHRINK: op = roll < 65 ? CMD_DELETE : roll < 78 ? CMD_INSERT :
                          roll < 99 ? CMD_SEARCH : CMD_CLEAR;
          default:   op = roll < 40 ? CMD_INSERT : roll < 70 ? CMD_DELETE :
                          roll < 97 ? CMD_SEARCH : CMD_CLEAR;
        endcase
        if ($urandom_range(0, 99) < 92) begin
          if (op == CMD_DELETE) begin
            pos = shadow_len == 0 ? '0 : POS_W'($urandom_range(0, shadow_len - 1));
          end else begin
            pos = POS_W'($urandom_range(0, shadow_len));
          end
        end else begin
          pos = POS_W'($urandom_range(0, 127));
        end
        key = pick_key();
        offer_command(op, pos, key, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      end
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS positional_array_list_top");
    end else begin
      $display("FAIL positional_array_list_top");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/apl_pkg.sv
hw/rtl/apl_store.sv
hw/rtl/apl_seq.sv
hw/rtl/positional_array_list_top.sv
hw/rtl/apl_checker.sv
dv/positional_array_list_checker.sv
dv/tb_positional_array_list_top.sv
